// ----- src/dotted_network_number_parser_defines.svh -----
// Assertion macros for the dotted network number parser.
// Included by the top level; expects clk and arst_n in scope.
`ifndef DOTTED_NETWORK_NUMBER_PARSER_DEFINES_SVH
`define DOTTED_NETWORK_NUMBER_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DNNP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dnnp assertion failed: same-cycle check");

// next-cycle implication, disabled during reset
`define DNNP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dnnp assertion failed: next-cycle check");

`endif

// ----- src/dnnp_pkg.sv -----
// Shared constants for the dotted network number parser.
// No dependencies; used by dotted_network_number_parser.
package dnnp_pkg;

	localparam int unsigned MAX_PARTS = 4;

	localparam int unsigned CH_W   = 8;
	localparam int unsigned NUM_W  = 32;
	localparam int unsigned TOT_W  = 3;
	localparam int unsigned ODATA_W = ((NUM_W + TOT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2
	} radix_t;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_DOT  = 8'h2e;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_UX   = 8'h58;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_LX   = 8'h78;
	localparam logic [7:0] HEX_OFS = 8'd10;

endpackage

// ----- src/dotted_network_number_parser.sv -----
// Dotted network number parser: one character per transfer, one result per string.
// A string's last character passes the input register, then the result register, before its result leaves on m_axis.
// Throughput: one character per cycle; the input register and result register
// keep both sides moving, stalled only while a result waits on m_axis_tready.
// Reset (arst_n low, asynchronous): clears valid flags and the parser state.
// Depends on dnnp_pkg and dotted_network_number_parser_defines.svh.
`include "dotted_network_number_parser_defines.svh"

module dotted_network_number_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [dnnp_pkg::CH_W-1:0]         s_axis_tdata,   // [7:0] ch
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [dnnp_pkg::ODATA_W-1:0]      m_axis_tdata,   // [31:0] net_number, [34:32] part_total
	output logic                              m_axis_tuser    // [0] bad_format
);

	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_ZERO   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_SKIP   = 2'd3
	} phase_t;

	logic                        valid_s1;
	logic [dnnp_pkg::CH_W-1:0]   ch_s1;

	phase_t                      phase_q;
	dnnp_pkg::radix_t            radix_q;
	logic [23:0]                 packed_q;
	logic [1:0]                  parts_q;
	logic [7:0]                  value_q;

	logic                        out_valid_q;
	logic [dnnp_pkg::NUM_W-1:0]  net_q;
	logic                        bad_q;
	logic [dnnp_pkg::TOT_W-1:0]  total_q;

	logic                        advance;
	logic                        step;

	phase_t                      phase_n;
	dnnp_pkg::radix_t            radix_n;
	logic [23:0]                 packed_n;
	logic [1:0]                  parts_n;
	logic [7:0]                  value_n;
	logic                        res_fire;
	logic                        res_bad;
	logic [dnnp_pkg::NUM_W-1:0]  res_net;
	logic [dnnp_pkg::TOT_W-1:0]  res_total;

	logic                        is_x;
	logic                        is_dec;
	logic                        is_lhex;
	logic                        is_uhex;
	logic                        is_space;
	logic                        is_digit;
	logic [7:0]                  dig8;
	logic [7:0]                  dig;
	logic [7:0]                  scaled;
	logic                        too_many;

	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	assign is_x     = (ch_s1 == dnnp_pkg::CH_LX) || (ch_s1 == dnnp_pkg::CH_UX);
	assign is_dec   = (ch_s1 >= dnnp_pkg::CH_0) && (ch_s1 <= dnnp_pkg::CH_9);
	assign is_lhex  = (ch_s1 >= dnnp_pkg::CH_LA) && (ch_s1 <= dnnp_pkg::CH_LF);
	assign is_uhex  = (ch_s1 >= dnnp_pkg::CH_UA) && (ch_s1 <= dnnp_pkg::CH_UF);
	assign is_space = (ch_s1 == dnnp_pkg::CH_SP) ||
	                  ((ch_s1 >= dnnp_pkg::CH_TAB) && (ch_s1 <= dnnp_pkg::CH_CR));
	assign too_many = ({1'b0, parts_q} + 3'd1) >= dnnp_pkg::TOT_W'(dnnp_pkg::MAX_PARTS);

	always_comb begin
		if (is_lhex) begin
			dig8 = ch_s1 - dnnp_pkg::CH_LA + dnnp_pkg::HEX_OFS;
		end else if (is_uhex) begin
			dig8 = ch_s1 - dnnp_pkg::CH_UA + dnnp_pkg::HEX_OFS;
		end else begin
			dig8 = ch_s1 - dnnp_pkg::CH_0;
		end
	end

	always_comb begin
		logic consumed;
		consumed  = 1'b0;
		phase_n   = phase_q;
		radix_n   = radix_q;
		packed_n  = packed_q;
		parts_n   = parts_q;
		value_n   = value_q;
		res_fire  = 1'b0;
		res_bad   = 1'b0;
		res_net   = {packed_q, value_q};
		res_total = {1'b0, parts_q} + 3'd1;
		is_digit  = 1'b0;
		dig       = dig8;
		scaled    = 8'd0;

		if (phase_q == PH_SKIP) begin
			consumed = 1'b1;
			if (ch_s1 == dnnp_pkg::CH_NUL) begin
				phase_n = PH_START;
			end
		end else if (phase_q == PH_START) begin
			if (ch_s1 == dnnp_pkg::CH_0) begin
				radix_n  = dnnp_pkg::RADIX_OCT;
				phase_n  = PH_ZERO;
				consumed = 1'b1;
			end else if (is_x) begin
				radix_n  = dnnp_pkg::RADIX_HEX;
				phase_n  = PH_DIGITS;
				consumed = 1'b1;
			end else begin
				radix_n = dnnp_pkg::RADIX_DEC;
				phase_n = PH_DIGITS;
			end
		end else if (phase_q == PH_ZERO) begin
			phase_n = PH_DIGITS;
			if (is_x) begin
				radix_n  = dnnp_pkg::RADIX_HEX;
				consumed = 1'b1;
			end
		end

		if (!consumed) begin
			is_digit = is_dec || ((radix_n == dnnp_pkg::RADIX_HEX) && (is_lhex || is_uhex));
			case (radix_n)
				dnnp_pkg::RADIX_HEX: scaled = {value_q[3:0], 4'b0000};
				dnnp_pkg::RADIX_OCT: scaled = {value_q[4:0], 3'b000};
				default:             scaled = {value_q[4:0], 3'b000} + {value_q[6:0], 1'b0};
			endcase
			if (is_digit) begin
				value_n = scaled + dig;
			end else if (ch_s1 == dnnp_pkg::CH_DOT) begin
				if (too_many) begin
					phase_n  = PH_SKIP;
					res_fire = 1'b1;
					res_bad  = 1'b1;
				end else begin
					packed_n = {packed_q[15:0], value_q};
					parts_n  = parts_q + 2'd1;
					value_n  = 8'd0;
					radix_n  = dnnp_pkg::RADIX_DEC;
					phase_n  = PH_START;
				end
			end else if (ch_s1 == dnnp_pkg::CH_NUL) begin
				phase_n  = PH_START;
				res_fire = 1'b1;
			end else begin
				phase_n  = PH_SKIP;
				res_fire = 1'b1;
				res_bad  = !is_space;
			end
		end

		if (res_fire) begin
			packed_n = 24'd0;
			parts_n  = 2'd0;
			value_n  = 8'd0;
			radix_n  = dnnp_pkg::RADIX_DEC;
			if (res_bad) begin
				res_net   = '1;
				res_total = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_START;
			radix_q     <= dnnp_pkg::RADIX_DEC;
			packed_q    <= 24'd0;
			parts_q     <= 2'd0;
			value_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (step) begin
				phase_q  <= phase_n;
				radix_q  <= radix_n;
				packed_q <= packed_n;
				parts_q  <= parts_n;
				value_q  <= value_n;
			end
			if (advance) begin
				out_valid_q <= step && res_fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1 <= s_axis_tdata;
		end
		if (step && res_fire) begin
			net_q   <= res_net;
			bad_q   <= res_bad;
			total_q <= res_total;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(dnnp_pkg::ODATA_W - dnnp_pkg::NUM_W - dnnp_pkg::TOT_W){1'b0}},
	                        total_q, net_q};
	assign m_axis_tuser  = bad_q;

	`DNNP_ASSERT_SAME(a_err_shape, out_valid_q && bad_q, (net_q == '1) && (total_q == '0))
	`DNNP_ASSERT_SAME(a_total_range, out_valid_q && !bad_q,
		(total_q == 3'd1) || (total_q == 3'd2) || (total_q == 3'd3) || (total_q == 3'd4))
	`DNNP_ASSERT_SAME(a_skip_clear, phase_q == PH_SKIP, (packed_q == 24'd0) && (parts_q == 2'd0))
	`DNNP_ASSERT_NEXT(a_result_out, step && res_fire, out_valid_q)

endmodule
